// ===== hw/rtl/kpmn_pkg.sv =====
// Package for the key press menu navigator.
// Holds the controller state type, command and status structs, register
// indexes and fixed widths. No dependencies.
package kpmn_pkg;

    // Key sample and counter widths
    localparam int KEY_W   = 3;
    localparam int CNT_W   = 8;
    localparam int SHOW_W  = 16;
    localparam int OPT_W   = 3;
    localparam int MASK_W  = 8;
    localparam int ADJ_W   = 2;
    localparam int CFG_A_W = 2;
    localparam int CFG_D_W = 16;

    localparam logic [KEY_W-1:0] KEYS_NONE = 3'b111;
    localparam logic [CNT_W-1:0] COUNT_MAX = 8'hff;

    // Adjust codes (two's complement)
    localparam logic [ADJ_W-1:0] ADJ_NONE  = 2'b00;
    localparam logic [ADJ_W-1:0] ADJ_PLUS  = 2'b01;
    localparam logic [ADJ_W-1:0] ADJ_MINUS = 2'b11;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_SHORT_TICKS  = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_LONG_TICKS   = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_SHOW_TICKS   = 2'd2;
    localparam logic [CFG_A_W-1:0] REG_VISIBLE_MASK = 2'd3;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SEARCH,
        ST_DONE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;     // register the input request
        logic eval;        // update press state, start option search
        logic step;        // one option search step
        logic load_out;    // move result into output register
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic adv_req;     // short option press with display on
        logic search_done; // search hit a visible option or ran out
        logic out_free;    // output register can take a result
    } dp_status_t;

endpackage

// ===== hw/rtl/kpmn_ctrl.sv =====
// Controller of the key press menu navigator.
// Sequences capture, evaluation, option search and output load.
// Depends on kpmn_pkg.
module kpmn_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  kpmn_pkg::dp_status_t  status,
    output kpmn_pkg::ctrl_cmd_t   cmd
);

    kpmn_pkg::state_t state_reg;
    kpmn_pkg::state_t state_next;
    logic             accept;

    assign accept = s_tvalid && s_tready;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= kpmn_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            kpmn_pkg::ST_IDLE: begin
                if (accept) state_next = kpmn_pkg::ST_EVAL;
            end
            kpmn_pkg::ST_EVAL: begin
                state_next = status.adv_req ? kpmn_pkg::ST_SEARCH : kpmn_pkg::ST_DONE;
            end
            kpmn_pkg::ST_SEARCH: begin
                if (status.search_done) state_next = kpmn_pkg::ST_DONE;
            end
            kpmn_pkg::ST_DONE: begin
                if (status.out_free) state_next = kpmn_pkg::ST_IDLE;
            end
            default: state_next = kpmn_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_tready     = 1'b0;
        cmd.capture  = 1'b0;
        cmd.eval     = 1'b0;
        cmd.step     = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            kpmn_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            kpmn_pkg::ST_EVAL: begin
                cmd.eval = 1'b1;
            end
            kpmn_pkg::ST_SEARCH: begin
                cmd.step = 1'b1;
            end
            kpmn_pkg::ST_DONE: begin
                cmd.load_out = status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.capture, cmd.eval, cmd.step, cmd.load_out}))
        else $error("kpmn_ctrl: more than one datapath command");
    a_accept_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == kpmn_pkg::ST_EVAL))
        else $error("kpmn_ctrl: accepted request not evaluated");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> status.out_free)
        else $error("kpmn_ctrl: load into busy output register");
    a_search_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kpmn_pkg::ST_SEARCH) && status.search_done
        |=> (state_reg == kpmn_pkg::ST_DONE))
        else $error("kpmn_ctrl: search finish not followed by output");
`endif

endmodule

// ===== hw/rtl/kpmn_dp.sv =====
// Datapath of the key press menu navigator.
// Config registers, press counter, display countdown, option search and
// output register. Depends on kpmn_pkg.
module kpmn_dp #(
    parameter int NUM_OPTIONS    = 8,
    parameter int DEFAULT_OPTION = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [kpmn_pkg::CFG_A_W-1:0]  cfg_addr,
    input  logic [kpmn_pkg::CFG_D_W-1:0]  cfg_wdata,
    input  logic [kpmn_pkg::KEY_W-1:0]    in_keys,
    input  kpmn_pkg::ctrl_cmd_t           cmd,
    output kpmn_pkg::dp_status_t          status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata
);

    localparam int IDX_W = (NUM_OPTIONS > 2) ? $clog2(NUM_OPTIONS) : 1;
    localparam logic [4:0] N5 = 5'(NUM_OPTIONS);
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(NUM_OPTIONS - 1);

    // Reduce a small value modulo the option count
    function automatic logic [4:0] mod_opt(input logic [4:0] v);
        logic [4:0] r;
        r = v;
        for (int i = 0; i < 8; i++) begin
            if (r >= N5) r = r - N5;
        end
        return r;
    endfunction

    // Configuration registers
    logic [kpmn_pkg::CNT_W-1:0]  short_ticks_reg;
    logic [kpmn_pkg::CNT_W-1:0]  long_ticks_reg;
    logic [kpmn_pkg::SHOW_W-1:0] show_ticks_reg;
    logic [kpmn_pkg::MASK_W-1:0] visible_mask_reg;

    // Tick state
    logic [kpmn_pkg::KEY_W-1:0]  keys_reg;
    logic [kpmn_pkg::CNT_W-1:0]  press_cnt_reg;
    logic [kpmn_pkg::CNT_W-1:0]  press_cnt_next;
    logic [kpmn_pkg::KEY_W-1:0]  latched_reg;
    logic [kpmn_pkg::KEY_W-1:0]  latched_next;
    logic [kpmn_pkg::OPT_W-1:0]  cur_opt_reg;
    logic [kpmn_pkg::SHOW_W-1:0] disp_cnt_reg;
    logic [kpmn_pkg::SHOW_W-1:0] disp_cnt_next;
    logic [kpmn_pkg::SHOW_W-1:0] disp_load;

    // Per-tick result
    logic [kpmn_pkg::ADJ_W-1:0]  adj_reg;
    logic [kpmn_pkg::ADJ_W-1:0]  adj_next;
    logic                        sp_reg;
    logic                        sp_next;
    logic                        lp_reg;
    logic                        lp_next;

    // Option search
    logic [IDX_W-1:0]            cand_reg;
    logic [IDX_W-1:0]            base_mod_reg;
    logic [IDX_W-1:0]            step_reg;
    logic [3:0]                  cand4;
    logic                        cand_vis;
    logic [4:0]                  cur_plus1;

    // Output register
    logic                        m_tvalid_reg;
    logic [7:0]                  m_tdata_reg;

    logic                        pressed;
    logic                        cnt_inc;
    logic                        adv_req;
    logic                        search_done;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_ticks_reg  <= 8'd5;
            long_ticks_reg   <= 8'd200;
            show_ticks_reg   <= 16'd300;
            visible_mask_reg <= 8'd231;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                kpmn_pkg::REG_SHORT_TICKS:  short_ticks_reg  <= cfg_wdata[7:0];
                kpmn_pkg::REG_LONG_TICKS:   long_ticks_reg   <= cfg_wdata[7:0];
                kpmn_pkg::REG_SHOW_TICKS:   show_ticks_reg   <= cfg_wdata;
                kpmn_pkg::REG_VISIBLE_MASK: visible_mask_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Press evaluation for the captured key sample
    always_comb begin
        pressed        = (keys_reg != kpmn_pkg::KEYS_NONE);
        cnt_inc        = pressed && (press_cnt_reg != kpmn_pkg::COUNT_MAX);
        press_cnt_next = press_cnt_reg;
        latched_next   = latched_reg;
        lp_next        = 1'b0;
        sp_next        = 1'b0;
        adj_next       = kpmn_pkg::ADJ_NONE;
        adv_req        = 1'b0;
        if (pressed) begin
            if (press_cnt_reg == '0) latched_next = keys_reg;
            if (cnt_inc) begin
                press_cnt_next = press_cnt_reg + 8'd1;
                lp_next        = (press_cnt_next == long_ticks_reg);
            end
        end else begin
            press_cnt_next = '0;
            sp_next = (press_cnt_reg != '0) && (press_cnt_reg < long_ticks_reg)
                      && (press_cnt_reg >= short_ticks_reg);
            if (sp_next) begin
                if (!latched_reg[0]) begin
                    adv_req = (disp_cnt_reg != '0);
                end else if (!latched_reg[1]) begin
                    adj_next = kpmn_pkg::ADJ_MINUS;
                end else if (!latched_reg[2]) begin
                    adj_next = kpmn_pkg::ADJ_PLUS;
                end
            end
        end
        disp_load     = sp_next ? show_ticks_reg : disp_cnt_reg;
        disp_cnt_next = (disp_load != '0) ? disp_load - 16'd1 : disp_load;
    end

    // Search candidate visibility
    always_comb begin
        cur_plus1   = 5'(cur_opt_reg) + 5'd1;
        cand4       = 4'(cand_reg);
        cand_vis    = !cand4[3] && visible_mask_reg[cand4[2:0]];
        search_done = cand_vis || (step_reg == LAST_STEP);
    end

    // Tick state and option search
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_cnt_reg <= '0;
            latched_reg   <= kpmn_pkg::KEYS_NONE;
            cur_opt_reg   <= kpmn_pkg::OPT_W'(DEFAULT_OPTION);
            disp_cnt_reg  <= '0;
        end else if (cmd.eval) begin
            press_cnt_reg <= press_cnt_next;
            latched_reg   <= latched_next;
            disp_cnt_reg  <= disp_cnt_next;
        end else if (cmd.step && search_done) begin
            cur_opt_reg <= cand_vis ? kpmn_pkg::OPT_W'(cand_reg)
                                    : kpmn_pkg::OPT_W'(base_mod_reg);
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) keys_reg <= in_keys;
        if (cmd.eval) begin
            adj_reg      <= adj_next;
            sp_reg       <= sp_next;
            lp_reg       <= lp_next;
            cand_reg     <= IDX_W'(mod_opt(cur_plus1));
            base_mod_reg <= IDX_W'(mod_opt(5'(cur_opt_reg)));
            step_reg     <= IDX_W'(1);
        end else if (cmd.step) begin
            cand_reg <= (cand_reg == LAST_STEP) ? '0 : cand_reg + IDX_W'(1);
            step_reg <= step_reg + IDX_W'(1);
        end
    end

    // Status to the controller
    assign status = '{adv_req: adv_req,
                      search_done: search_done,
                      out_free: (!m_tvalid_reg || m_tready)};

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= {(disp_cnt_reg != '0), lp_reg, sp_reg, adj_reg, cur_opt_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hw/rtl/key_press_menu_navigator.sv =====
// Top level of the key press menu navigator.
// Joins the controller and the datapath. Depends on kpmn_pkg, kpmn_ctrl,
// kpmn_dp.
//
// Usage: send one request per key sample tick on the s_ channel; s_tdata[2:0]
// holds the active-low keys (bit0 option, bit1 minus, bit2 plus). Each
// request yields exactly one result on the m_ channel.
// An accepted request passes ST_EVAL and then ST_DONE, where the result
// is loaded into the output register; an option advance puts ST_SEARCH
// between them, one search step per option examined, up to NUM_OPTIONS - 1.
// The search unit checks one option per cycle. s_tready is low until the load.
// The result sits in an output register, so the next request is taken
// while a finished result waits; if the receiver stalls longer, the block
// holds the next result internally and s_tready stays low until it moves.
// Reset (aresetn low, synchronous) restores the register defaults, clears
// the press and display counters, drops m_tvalid and selects DEFAULT_OPTION.
// Configuration writes via cfg_we/cfg_addr/cfg_wdata take effect at once;
// write only while no request is in flight.
module key_press_menu_navigator #(
    parameter int NUM_OPTIONS    = 8,
    parameter int DEFAULT_OPTION = 0
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    // Key sample requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [2:0] key_levels, [7:3] zero
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [2:0] selected_option, [4:3] adjust,
                                   // [5] short_press, [6] long_press,
                                   // [7] display_on
);

    kpmn_pkg::ctrl_cmd_t  cmd;
    kpmn_pkg::dp_status_t status;

    kpmn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    kpmn_dp #(
        .NUM_OPTIONS    (NUM_OPTIONS),
        .DEFAULT_OPTION (DEFAULT_OPTION)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_keys   (s_tdata[2:0]),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
